// ----- rtl/etrt_pkg.sv -----
package etrt_pkg;

  localparam int MAX_RULES = 16;
  localparam int MAX_QUEUE = 7;
  localparam int IDX_W     = $clog2(MAX_RULES);
  localparam int CNT_W     = $clog2(MAX_RULES + 1);
  localparam int TYPE_W    = 16;
  localparam int QUEUE_W   = 3;
  localparam int SLOT_W    = TYPE_W + QUEUE_W;
  localparam int CMP_W     = 9;

  localparam logic [TYPE_W-1:0] FULL_TYPE_MASK = '1;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_DEL   = 3'd1;
  localparam logic [2:0] OP_GET   = 3'd2;
  localparam logic [2:0] OP_LIST  = 3'd3;
  localparam logic [2:0] OP_FLUSH = 3'd4;

  localparam logic [2:0] STAT_OK          = 3'd0;
  localparam logic [2:0] STAT_UNSUPPORTED = 3'd1;
  localparam logic [2:0] STAT_INVALID     = 3'd2;
  localparam logic [2:0] STAT_NOSPACE     = 3'd3;
  localparam logic [2:0] STAT_EXISTS      = 3'd4;
  localparam logic [2:0] STAT_NOTFOUND    = 3'd5;
  localparam logic [2:0] STAT_OVERFLOW    = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_TAIL,
    S_FINISH,
    S_GET,
    S_LIST,
    S_LIST_END
  } state_t;

  typedef enum logic [2:0] {
    RES_PRE,
    RES_ADD,
    RES_DEL,
    RES_GET,
    RES_ITEM,
    RES_LIST_END,
    RES_FLUSH,
    RES_BAD
  } res_t;

  typedef struct packed {
    logic capture;
    logic scan_clear;
    logic advance;
    logic probe;
    logic mark_ovf;
    logic emit;
    res_t kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       pre_fail;
    logic       scan_last;
    logic       list_hit;
    logic       list_full;
  } ctrl_stat_t;

endpackage

// ----- rtl/etrt_ram.sv -----
module etrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/etrt_ctrl.sv -----
module etrt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  etrt_pkg::ctrl_stat_t  stat,
  output etrt_pkg::ctrl_cmd_t   cmd,
  output logic                  busy
);

  etrt_pkg::state_t state;
  etrt_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= etrt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      etrt_pkg::S_IDLE: begin
        if (start) state_next = etrt_pkg::S_DISPATCH;
      end
      etrt_pkg::S_DISPATCH: begin
        case (stat.op)
          etrt_pkg::OP_ADD:  state_next = stat.pre_fail ? etrt_pkg::S_IDLE : etrt_pkg::S_SCAN;
          etrt_pkg::OP_GET:  state_next = etrt_pkg::S_GET;
          etrt_pkg::OP_LIST: state_next = etrt_pkg::S_LIST;
          default:           state_next = etrt_pkg::S_IDLE;
        endcase
      end
      etrt_pkg::S_SCAN: begin
        if (stat.scan_last) state_next = etrt_pkg::S_TAIL;
      end
      etrt_pkg::S_TAIL:   state_next = etrt_pkg::S_FINISH;
      etrt_pkg::S_FINISH: state_next = etrt_pkg::S_IDLE;
      etrt_pkg::S_GET:    state_next = etrt_pkg::S_IDLE;
      etrt_pkg::S_LIST: begin
        if ((stat.list_hit && stat.list_full) || stat.scan_last) begin
          state_next = etrt_pkg::S_LIST_END;
        end
      end
      etrt_pkg::S_LIST_END: state_next = etrt_pkg::S_IDLE;
      default:              state_next = etrt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.kind       = etrt_pkg::RES_BAD;
    busy           = 1'b1;
    case (state)
      etrt_pkg::S_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      etrt_pkg::S_DISPATCH: begin
        cmd.scan_clear = 1'b1;
        case (stat.op)
          etrt_pkg::OP_ADD: begin
            cmd.emit = stat.pre_fail;
            cmd.kind = etrt_pkg::RES_PRE;
          end
          etrt_pkg::OP_DEL: begin
            cmd.emit = 1'b1;
            cmd.kind = etrt_pkg::RES_DEL;
          end
          etrt_pkg::OP_GET, etrt_pkg::OP_LIST: begin
            cmd.emit = 1'b0;
          end
          etrt_pkg::OP_FLUSH: begin
            cmd.emit = 1'b1;
            cmd.kind = etrt_pkg::RES_FLUSH;
          end
          default: begin
            cmd.emit = 1'b1;
            cmd.kind = etrt_pkg::RES_BAD;
          end
        endcase
      end
      etrt_pkg::S_SCAN: begin
        cmd.advance = 1'b1;
        cmd.probe   = 1'b1;
      end
      etrt_pkg::S_TAIL: begin
        cmd.emit = 1'b0;
      end
      etrt_pkg::S_FINISH: begin
        cmd.emit = 1'b1;
        cmd.kind = etrt_pkg::RES_ADD;
      end
      etrt_pkg::S_GET: begin
        cmd.emit = 1'b1;
        cmd.kind = etrt_pkg::RES_GET;
      end
      etrt_pkg::S_LIST: begin
        cmd.advance  = 1'b1;
        // stop at the first valid slot beyond the capacity
        cmd.mark_ovf = stat.list_hit && stat.list_full;
        cmd.emit     = stat.list_hit && !stat.list_full;
        cmd.kind     = etrt_pkg::RES_ITEM;
      end
      etrt_pkg::S_LIST_END: begin
        cmd.emit = 1'b1;
        cmd.kind = etrt_pkg::RES_LIST_END;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/etrt_dp.sv -----
module etrt_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  etrt_pkg::ctrl_cmd_t   cmd,
  output etrt_pkg::ctrl_stat_t  stat,
  input  logic                  cfg_write,
  input  logic [4:0]            cfg_data,
  input  logic [2:0]            command,
  input  logic [7:0]            location,
  input  logic                  any_location,
  input  logic                  flow_is_ether,
  input  logic                  addr_masks_zero,
  input  logic [15:0]           type_mask,
  input  logic [15:0]           ether_type,
  input  logic [7:0]            queue_request,
  input  logic [7:0]            list_capacity,
  output logic                  result_valid,
  output logic [2:0]            status,
  output logic [3:0]            location_out,
  output logic [15:0]           ether_type_out,
  output logic [2:0]            queue_out,
  output logic [4:0]            limit_out,
  output logic [4:0]            count_out,
  output logic                  last
);

  localparam int IDX_W  = etrt_pkg::IDX_W;
  localparam int CNT_W  = etrt_pkg::CNT_W;
  localparam int CMP_W  = etrt_pkg::CMP_W;
  localparam int SLOT_W = etrt_pkg::SLOT_W;
  localparam int QW     = etrt_pkg::QUEUE_W;

  logic [4:0]                   rule_limit;
  logic [etrt_pkg::MAX_RULES-1:0] slot_valid;

  logic [2:0]  cap_cmd;
  logic [7:0]  cap_loc;
  logic        cap_any;
  logic        cap_ether;
  logic        cap_masks;
  logic [15:0] cap_tmask;
  logic [15:0] cap_et;
  logic [7:0]  cap_q;
  logic [7:0]  cap_cap;

  logic [IDX_W-1:0] scan_idx;
  logic [IDX_W-1:0] cmp_idx;
  logic             cmp_live;
  logic             exists;
  logic             ovf;
  logic [CNT_W-1:0] list_cnt;

  logic [CMP_W-1:0] lim;
  logic [IDX_W-1:0] loc_idx;
  logic             loc_hit;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] target;
  logic             unsup;
  logic             bad_q;
  logic             bad_loc;
  logic             add_ok;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_raddr;
  logic [SLOT_W-1:0] ram_rdata;

  logic [2:0]  status_next;
  logic [3:0]  location_next;
  logic [15:0] ether_type_next;
  logic [2:0]  queue_next;
  logic [4:0]  limit_next;
  logic [4:0]  count_next;
  logic        last_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_limit <= 5'(etrt_pkg::MAX_RULES);
    end else if (cfg_write) begin
      rule_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_cmd   <= command;
      cap_loc   <= location;
      cap_any   <= any_location;
      cap_ether <= flow_is_ether;
      cap_masks <= addr_masks_zero;
      cap_tmask <= type_mask;
      cap_et    <= ether_type;
      cap_q     <= queue_request;
      cap_cap   <= list_capacity;
    end
  end

  // decode of the held request
  always_comb begin
    lim = (CMP_W'(rule_limit) < CMP_W'(etrt_pkg::MAX_RULES))
        ? CMP_W'(rule_limit) : CMP_W'(etrt_pkg::MAX_RULES);
    loc_idx = cap_loc[IDX_W-1:0];
    loc_hit = (CMP_W'(cap_loc) < CMP_W'(etrt_pkg::MAX_RULES)) && slot_valid[loc_idx];
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < etrt_pkg::MAX_RULES; i++) begin
      if (!free_found && (CMP_W'(i) < lim) && !slot_valid[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
    target  = cap_any ? free_idx : loc_idx;
    unsup   = !cap_ether || !cap_masks || (cap_tmask != etrt_pkg::FULL_TYPE_MASK);
    bad_q   = CMP_W'(cap_q) > CMP_W'(etrt_pkg::MAX_QUEUE);
    bad_loc = !cap_any && (CMP_W'(cap_loc) >= lim);
    add_ok  = !exists;
  end

  always_comb begin
    stat.op        = cap_cmd;
    stat.pre_fail  = unsup || bad_q || bad_loc || (cap_any && !free_found);
    stat.scan_last = scan_idx == IDX_W'(etrt_pkg::MAX_RULES - 1);
    stat.list_hit  = slot_valid[scan_idx];
    stat.list_full = CMP_W'(list_cnt) == CMP_W'(cap_cap);
  end

  // sweep for an equal EtherType at another slot, one RAM read a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_live <= 1'b0;
    end else begin
      cmp_live <= cmd.probe;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmd.scan_clear) begin
      scan_idx <= '0;
      exists   <= 1'b0;
      ovf      <= 1'b0;
      list_cnt <= '0;
    end else begin
      if (cmd.advance) begin
        scan_idx <= scan_idx + IDX_W'(1);
      end
      if (cmp_live && slot_valid[cmp_idx] && (cmp_idx != target)
          && (ram_rdata[SLOT_W-1:QW] == cap_et)) begin
        exists <= 1'b1;
      end
      if (cmd.mark_ovf) begin
        ovf <= 1'b1;
      end
      if (cmd.emit && cmd.kind == etrt_pkg::RES_ITEM) begin
        list_cnt <= list_cnt + CNT_W'(1);
      end
    end
  end

  assign ram_we    = cmd.emit && (cmd.kind == etrt_pkg::RES_ADD) && add_ok;
  assign ram_raddr = cmd.probe ? scan_idx : loc_idx;

  etrt_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (etrt_pkg::MAX_RULES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (target),
    .wdata ({cap_et, cap_q[QW-1:0]}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.emit) begin
      if (cmd.kind == etrt_pkg::RES_FLUSH) begin
        slot_valid <= '0;
      end else if (cmd.kind == etrt_pkg::RES_DEL && loc_hit) begin
        slot_valid[loc_idx] <= 1'b0;
      end else if (ram_we) begin
        slot_valid[target] <= 1'b1;
      end
    end
  end

  always_comb begin
    status_next     = etrt_pkg::STAT_OK;
    location_next   = '0;
    ether_type_next = '0;
    queue_next      = '0;
    limit_next      = '0;
    count_next      = '0;
    last_next       = 1'b1;
    case (cmd.kind)
      etrt_pkg::RES_PRE: begin
        if (unsup) begin
          status_next = etrt_pkg::STAT_UNSUPPORTED;
        end else if (bad_q || bad_loc) begin
          status_next = etrt_pkg::STAT_INVALID;
        end else begin
          status_next = etrt_pkg::STAT_NOSPACE;
        end
      end
      etrt_pkg::RES_ADD: begin
        status_next   = add_ok ? etrt_pkg::STAT_OK : etrt_pkg::STAT_EXISTS;
        location_next = add_ok ? 4'(target) : 4'd0;
      end
      etrt_pkg::RES_DEL: begin
        status_next = loc_hit ? etrt_pkg::STAT_OK : etrt_pkg::STAT_NOTFOUND;
      end
      etrt_pkg::RES_GET: begin
        limit_next = rule_limit;
        if (loc_hit) begin
          ether_type_next = ram_rdata[SLOT_W-1:QW];
          queue_next      = ram_rdata[QW-1:0];
        end else begin
          status_next = etrt_pkg::STAT_NOTFOUND;
        end
      end
      etrt_pkg::RES_ITEM: begin
        location_next = 4'(scan_idx);
        limit_next    = rule_limit;
        last_next     = 1'b0;
      end
      etrt_pkg::RES_LIST_END: begin
        status_next = ovf ? etrt_pkg::STAT_OVERFLOW : etrt_pkg::STAT_OK;
        limit_next  = rule_limit;
        count_next  = 5'(list_cnt);
      end
      etrt_pkg::RES_FLUSH: begin
        status_next = etrt_pkg::STAT_OK;
      end
      default: begin
        status_next = etrt_pkg::STAT_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status         <= status_next;
      location_out   <= location_next;
      ether_type_out <= ether_type_next;
      queue_out      <= queue_next;
      limit_out      <= limit_next;
      count_out      <= count_next;
      last           <= last_next;
    end
  end

endmodule

// ----- rtl/ethertype_rule_table_unit.sv -----
// Every command passes a dispatch state after accept; delete, flush, bad codes and adds refused
// up front emit their word there, get in the next state, and an add after the EtherType sweep.
// List walks the 16 slots, one word per valid slot up to list_capacity, then a final word.
// One command at a time: busy drops as the last word is strobed, so the next command is
// accepted at the edge that takes that word at the earliest; results cannot stall.
// Synchronous reset clears every valid mark and sets rule_limit to 16; slot contents are kept.
module ethertype_rule_table_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic [2:0]  command,
  input  logic [7:0]  location,
  input  logic        any_location,
  input  logic        flow_is_ether,
  input  logic        addr_masks_zero,
  input  logic [15:0] type_mask,
  input  logic [15:0] ether_type,
  input  logic [7:0]  queue_request,
  input  logic [7:0]  list_capacity,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [3:0]  location_out,
  output logic [15:0] ether_type_out,
  output logic [2:0]  queue_out,
  output logic [4:0]  limit_out,
  output logic [4:0]  count_out,
  output logic        last
);

  etrt_pkg::ctrl_cmd_t  cmd;
  etrt_pkg::ctrl_stat_t stat;

  assign cfg_ready = !busy;

  etrt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  etrt_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .cfg_write       (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .command         (command),
    .location        (location),
    .any_location    (any_location),
    .flow_is_ether   (flow_is_ether),
    .addr_masks_zero (addr_masks_zero),
    .type_mask       (type_mask),
    .ether_type      (ether_type),
    .queue_request   (queue_request),
    .list_capacity   (list_capacity),
    .result_valid    (result_valid),
    .status          (status),
    .location_out    (location_out),
    .ether_type_out  (ether_type_out),
    .queue_out       (queue_out),
    .limit_out       (limit_out),
    .count_out       (count_out),
    .last            (last)
  );

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb;

  localparam int CLK_HALF = 10;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_PER_PHASE = 28;
  localparam logic [2:0] OP_BAD_LO = 3'd5;
  localparam logic [2:0] OP_BAD_HI = 3'd7;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  location;
    logic        any_location;
    logic        flow_is_ether;
    logic        addr_masks_zero;
    logic [15:0] type_mask;
    logic [15:0] ether_type;
    logic [7:0]  queue_request;
    logic [7:0]  list_capacity;
  } rule_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  location_out;
    logic [15:0] ether_type_out;
    logic [2:0]  queue_out;
    logic [4:0]  limit_out;
    logic [4:0]  count_out;
    logic        last;
  } rule_word_t;

  typedef struct packed {
    rule_cmd_t  c;
    logic       pinned;
    rule_word_t w;
    logic       relimit;
    logic [4:0] limit;
  } plan_row_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  cfg_data;
  logic [2:0]  command;
  logic [7:0]  location;
  logic        any_location;
  logic        flow_is_ether;
  logic        addr_masks_zero;
  logic [15:0] type_mask;
  logic [15:0] ether_type;
  logic [7:0]  queue_request;
  logic [7:0]  list_capacity;
  logic        result_valid;
  logic [2:0]  status;
  logic [3:0]  location_out;
  logic [15:0] ether_type_out;
  logic [2:0]  queue_out;
  logic [4:0]  limit_out;
  logic [4:0]  count_out;
  logic        last;

  // shadow copy of the rule table
  logic [4:0]  tbl_limit;
  bit          tbl_valid [etrt_pkg::MAX_RULES];
  logic [15:0] tbl_type [etrt_pkg::MAX_RULES];
  logic [2:0]  tbl_queue [etrt_pkg::MAX_RULES];

  rule_word_t  pending_words [$];
  rule_word_t  cmd_words [$];
  rule_word_t  want;
  plan_row_t   plan [32];
  int          n_rows;
  int          mismatches;
  int          cycle_count;
  int          sender_idle_pct;

  ethertype_rule_table_unit dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .command         (command),
    .location        (location),
    .any_location    (any_location),
    .flow_is_ether   (flow_is_ether),
    .addr_masks_zero (addr_masks_zero),
    .type_mask       (type_mask),
    .ether_type      (ether_type),
    .queue_request   (queue_request),
    .list_capacity   (list_capacity),
    .result_valid    (result_valid),
    .status          (status),
    .location_out    (location_out),
    .ether_type_out  (ether_type_out),
    .queue_out       (queue_out),
    .limit_out       (limit_out),
    .count_out       (count_out),
    .last            (last)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("ERROR at %0t: %s", $time, what);
    mismatches++;
  endtask

  // Works out the words one command produces and updates the shadow table.
  function automatic void predict_rule_cmd(input rule_cmd_t c);
    rule_word_t w;
    int lim;
    int pick;
    int k;
    logic [2:0] st;
    bit hit;
    cmd_words.delete();
    w = '0;
    w.last = 1'b1;
    lim = (tbl_limit < etrt_pkg::MAX_RULES) ? int'(tbl_limit) : etrt_pkg::MAX_RULES;
    hit = (c.location < etrt_pkg::MAX_RULES) ?
          tbl_valid[c.location[etrt_pkg::IDX_W-1:0]] : 1'b0;
    case (c.command)
      etrt_pkg::OP_ADD: begin
        st = etrt_pkg::STAT_OK;
        pick = int'(c.location);
        if (!c.flow_is_ether || !c.addr_masks_zero ||
            c.type_mask != etrt_pkg::FULL_TYPE_MASK) begin
          st = etrt_pkg::STAT_UNSUPPORTED;
        end else if (c.queue_request > etrt_pkg::MAX_QUEUE) begin
          st = etrt_pkg::STAT_INVALID;
        end else if (!c.any_location && c.location >= lim) begin
          st = etrt_pkg::STAT_INVALID;
        end else begin
          if (c.any_location) begin
            pick = -1;
            for (int i = 0; i < lim; i++)
              if (!tbl_valid[i] && pick < 0) pick = i;
            if (pick < 0) st = etrt_pkg::STAT_NOSPACE;
          end
          if (st == etrt_pkg::STAT_OK)
            for (int i = 0; i < etrt_pkg::MAX_RULES; i++)
              if (tbl_valid[i] && tbl_type[i] == c.ether_type && i != pick)
                st = etrt_pkg::STAT_EXISTS;
          if (st == etrt_pkg::STAT_OK) begin
            tbl_valid[pick] = 1'b1;
            tbl_type[pick] = c.ether_type;
            tbl_queue[pick] = c.queue_request[2:0];
            w.location_out = pick[3:0];
          end
        end
        w.status = st;
        cmd_words.push_back(w);
      end
      etrt_pkg::OP_DEL: begin
        if (hit) tbl_valid[c.location[etrt_pkg::IDX_W-1:0]] = 1'b0;
        w.status = hit ? etrt_pkg::STAT_OK : etrt_pkg::STAT_NOTFOUND;
        cmd_words.push_back(w);
      end
      etrt_pkg::OP_GET: begin
        w.limit_out = tbl_limit;
        if (hit) begin
          w.status = etrt_pkg::STAT_OK;
          w.ether_type_out = tbl_type[c.location[etrt_pkg::IDX_W-1:0]];
          w.queue_out = tbl_queue[c.location[etrt_pkg::IDX_W-1:0]];
        end else begin
          w.status = etrt_pkg::STAT_NOTFOUND;
        end
        cmd_words.push_back(w);
      end
      etrt_pkg::OP_LIST: begin
        k = 0;
        st = etrt_pkg::STAT_OK;
        w.limit_out = tbl_limit;
        for (int i = 0; i < etrt_pkg::MAX_RULES; i++) begin
          if (tbl_valid[i]) begin
            if (k == c.list_capacity) begin
              st = etrt_pkg::STAT_OVERFLOW;
              break;
            end
            w.status = etrt_pkg::STAT_OK;
            w.location_out = i[3:0];
            w.last = 1'b0;
            cmd_words.push_back(w);
            k++;
          end
        end
        w.status = st;
        w.location_out = '0;
        w.count_out = k[4:0];
        w.last = 1'b1;
        cmd_words.push_back(w);
      end
      etrt_pkg::OP_FLUSH: begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        w.status = etrt_pkg::STAT_OK;
        cmd_words.push_back(w);
      end
      default: begin
        w.status = etrt_pkg::STAT_INVALID;
        cmd_words.push_back(w);
      end
    endcase
  endfunction

  function automatic rule_cmd_t random_cmd();
    rule_cmd_t c;
    int r;
    int lim;
    lim = (tbl_limit < etrt_pkg::MAX_RULES) ? int'(tbl_limit) : etrt_pkg::MAX_RULES;
    c.command = 3'($urandom_range(7));
    c.location = 8'($urandom);
    c.any_location = 1'($urandom);
    c.flow_is_ether = 1'($urandom);
    c.addr_masks_zero = 1'($urandom);
    c.type_mask = 16'($urandom);
    c.ether_type = 16'($urandom);
    c.queue_request = 8'($urandom);
    c.list_capacity = 8'($urandom);
    r = $urandom_range(99);
    if (r < 50) begin
      c.command = etrt_pkg::OP_ADD;
      c.flow_is_ether = 1'b1;
      c.addr_masks_zero = 1'b1;
      c.type_mask = etrt_pkg::FULL_TYPE_MASK;
      if ($urandom_range(9) != 0) c.queue_request = 8'($urandom_range(etrt_pkg::MAX_QUEUE));
      if (!c.any_location && lim > 0 && $urandom_range(6) != 0)
        c.location = 8'($urandom_range(lim - 1));
      // reuse a few common types so duplicate rejects happen
      if ($urandom_range(9) < 7) begin
        case ($urandom_range(3))
          0: c.ether_type = 16'h0800;
          1: c.ether_type = 16'h86DD;
          2: c.ether_type = 16'h88F7;
          default: c.ether_type = 16'hFFFF;
        endcase
      end
    end else if (r < 65) begin
      c.command = etrt_pkg::OP_DEL;
      if ($urandom_range(7) != 0) c.location = 8'($urandom_range(etrt_pkg::MAX_RULES - 1));
    end else if (r < 78) begin
      c.command = etrt_pkg::OP_GET;
      if ($urandom_range(7) != 0) c.location = 8'($urandom_range(etrt_pkg::MAX_RULES - 1));
    end else if (r < 88) begin
      c.command = etrt_pkg::OP_LIST;
      if ($urandom_range(1) != 0)
        c.list_capacity = 8'($urandom_range(etrt_pkg::MAX_RULES + 1));
    end else if (r < 91) begin
      c.command = etrt_pkg::OP_FLUSH;
    end
    return c;
  endfunction

  task automatic issue_cmd(input rule_cmd_t c, input logic pinned, input rule_word_t pin_w);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    command <= c.command;
    location <= c.location;
    any_location <= c.any_location;
    flow_is_ether <= c.flow_is_ether;
    addr_masks_zero <= c.addr_masks_zero;
    type_mask <= c.type_mask;
    ether_type <= c.ether_type;
    queue_request <= c.queue_request;
    list_capacity <= c.list_capacity;
    do @(posedge clk); while (busy);
    predict_rule_cmd(c);
    if (pinned) pending_words.push_back(pin_w);
    else foreach (cmd_words[i]) pending_words.push_back(cmd_words[i]);
    @(negedge clk);
  endtask

  // hold the sender until every pending word has come back
  task automatic wait_drained();
    start <= 1'b0;
    do @(negedge clk); while (pending_words.size() != 0);
  endtask

  task automatic write_limit(input logic [4:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tbl_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_row(input logic [2:0] cmd, input logic [7:0] loc, input logic any,
                         input logic [15:0] et, input logic [7:0] q, input logic [7:0] cap);
    plan[n_rows] = '0;
    plan[n_rows].c = '{cmd, loc, any, 1'b1, 1'b1, etrt_pkg::FULL_TYPE_MASK, et, q, cap};
    n_rows++;
  endtask

  task automatic pin(input logic [2:0] st, input logic [3:0] loc, input logic [4:0] lim,
                     input logic [4:0] cnt);
    plan[n_rows-1].pinned = 1'b1;
    plan[n_rows-1].w = '{st, loc, 16'h0000, 3'd0, lim, cnt, 1'b1};
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (pending_words.size() == 0) begin
        flag_mismatch("result word with nothing pending");
      end else begin
        want = pending_words.pop_front();
        if (status !== want.status || location_out !== want.location_out ||
            ether_type_out !== want.ether_type_out || queue_out !== want.queue_out ||
            limit_out !== want.limit_out || count_out !== want.count_out ||
            last !== want.last)
          flag_mismatch($sformatf(
            {"got st=%0d loc=%0d et=%h q=%0d lim=%0d cnt=%0d last=%0d, ",
             "want %0d %0d %h %0d %0d %0d %0d"},
            status, location_out, ether_type_out, queue_out, limit_out, count_out, last,
            want.status, want.location_out, want.ether_type_out, want.queue_out,
            want.limit_out, want.count_out, want.last));
      end
    end
  end

  initial begin
    logic [4:0] phase_limit [3];
    int         phase_idle [3];
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    command = etrt_pkg::OP_FLUSH;
    location = '0;
    any_location = 1'b0;
    flow_is_ether = 1'b0;
    addr_masks_zero = 1'b0;
    type_mask = '0;
    ether_type = '0;
    queue_request = '0;
    list_capacity = '0;
    mismatches = 0;
    cycle_count = 0;
    sender_idle_pct = 0;
    n_rows = 0;
    tbl_limit = 5'd16;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    phase_limit = '{5'd16, 5'd3, 5'd13};
    phase_idle = '{25, 81, 0};

    // empty table right after reset
    add_row(etrt_pkg::OP_GET, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_NOTFOUND, 0, 16, 0);
    add_row(etrt_pkg::OP_DEL, 8'd255, 1'b0, 16'h0000, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_NOTFOUND, 0, 0, 0);
    add_row(etrt_pkg::OP_LIST, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_OK, 0, 16, 0);
    // malformed specs
    add_row(etrt_pkg::OP_ADD, 8'd0, 1'b0, 16'h1234, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_UNSUPPORTED, 0, 0, 0);
    plan[n_rows-1].c.flow_is_ether = 1'b0;
    add_row(etrt_pkg::OP_ADD, 8'd0, 1'b0, 16'h1234, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_UNSUPPORTED, 0, 0, 0);
    plan[n_rows-1].c.addr_masks_zero = 1'b0;
    add_row(etrt_pkg::OP_ADD, 8'd0, 1'b0, 16'h1234, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_UNSUPPORTED, 0, 0, 0);
    plan[n_rows-1].c.type_mask = 16'h7FFF;
    add_row(etrt_pkg::OP_ADD, 8'd0, 1'b0, 16'h1234, 8'd8, 8'd0);
    pin(etrt_pkg::STAT_INVALID, 0, 0, 0);
    add_row(etrt_pkg::OP_ADD, 8'd0, 1'b1, 16'h1234, 8'd255, 8'd0);
    pin(etrt_pkg::STAT_INVALID, 0, 0, 0);
    add_row(etrt_pkg::OP_ADD, 8'd16, 1'b0, 16'h1234, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_INVALID, 0, 0, 0);
    add_row(etrt_pkg::OP_ADD, 8'd255, 1'b0, 16'h1234, 8'd7, 8'd0);
    pin(etrt_pkg::STAT_INVALID, 0, 0, 0);
    // fill both ends, pick lowest free, duplicate and in-place replace
    add_row(etrt_pkg::OP_ADD, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_OK, 0, 0, 0);
    add_row(etrt_pkg::OP_ADD, 8'd15, 1'b0, 16'hFFFF, 8'd7, 8'd0);
    pin(etrt_pkg::STAT_OK, 15, 0, 0);
    add_row(etrt_pkg::OP_ADD, 8'd0, 1'b1, 16'h88F7, 8'd3, 8'd0);
    add_row(etrt_pkg::OP_ADD, 8'd5, 1'b0, 16'hFFFF, 8'd1, 8'd0);
    pin(etrt_pkg::STAT_EXISTS, 0, 0, 0);
    add_row(etrt_pkg::OP_ADD, 8'd15, 1'b0, 16'hFFFF, 8'd2, 8'd0);
    add_row(etrt_pkg::OP_GET, 8'd15, 1'b0, 16'h0000, 8'd0, 8'd0);
    add_row(etrt_pkg::OP_LIST, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd255);
    add_row(etrt_pkg::OP_LIST, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd2);
    add_row(etrt_pkg::OP_DEL, 8'd1, 1'b0, 16'h0000, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_OK, 0, 0, 0);
    add_row(OP_BAD_LO, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_INVALID, 0, 0, 0);
    add_row(OP_BAD_HI, 8'd255, 1'b1, 16'hFFFF, 8'd255, 8'd255);
    pin(etrt_pkg::STAT_INVALID, 0, 0, 0);
    add_row(etrt_pkg::OP_FLUSH, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_OK, 0, 0, 0);
    // no usable slots at all
    add_row(etrt_pkg::OP_ADD, 8'd0, 1'b1, 16'h0800, 8'd1, 8'd0);
    pin(etrt_pkg::STAT_NOSPACE, 0, 0, 0);
    plan[n_rows-1].relimit = 1'b1;
    plan[n_rows-1].limit = 5'd0;
    add_row(etrt_pkg::OP_ADD, 8'd0, 1'b0, 16'h0800, 8'd1, 8'd0);
    pin(etrt_pkg::STAT_INVALID, 0, 0, 0);
    add_row(etrt_pkg::OP_GET, 8'd0, 1'b0, 16'h0000, 8'd0, 8'd0);
    pin(etrt_pkg::STAT_NOTFOUND, 0, 0, 0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < n_rows; i++) begin
      if (plan[i].relimit) begin
        wait_drained();
        write_limit(plan[i].limit);
      end
      issue_cmd(plan[i].c, plan[i].pinned, plan[i].w);
    end

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      write_limit(phase_limit[ph]);
      sender_idle_pct = phase_idle[ph];
      repeat (RANDOM_PER_PHASE) begin
        if ($urandom_range(19) == 0) wait_drained();
        issue_cmd(random_cmd(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
